// ===== design/bpdn_pkg.sv =====
// ----------------------------------------------------------------------------
// bpdn_pkg
// types and constants shared by the deepest node finder modules
// ----------------------------------------------------------------------------
package bpdn_pkg;

    localparam int KEY_W       = 32;
    localparam int LEVEL_W     = 10;
    localparam int M_TDATA_W   = 48;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd1023;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [LEVEL_W-1:0]      level_t;

    typedef struct packed {
        key_t   key;
        level_t level;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input word
        logic start;     // root of a new sequence
        logic push_gt;   // push above top
        logic pop;       // drop top, fetch next one
        logic load_top;  // take fetched entry as top
        logic push_pop;  // push below last popped entry
        logic emit;      // load result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start;
        logic gt;
        logic lt;
        logic empty;
        logic last;
    } status_t;

    function automatic level_t level_inc(input level_t lvl);
        level_inc = (lvl == LEVEL_MAX) ? LEVEL_MAX : lvl + level_t'(1);
    endfunction

endpackage

// ===== design/bpdn_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpdn_ctrl
// sequencer for the stack walk and the result handshake
// ----------------------------------------------------------------------------
module bpdn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  bpdn_pkg::status_t status,
    output bpdn_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       can_emit;
    logic       finish;

    assign can_emit = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        finish     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (status.start) begin
                    cmd.start = 1'b1;
                    finish    = 1'b1;
                end else if (status.gt) begin
                    cmd.push_gt = 1'b1;
                    finish      = 1'b1;
                end else if (status.lt) begin
                    cmd.pop    = 1'b1;
                    state_next = S_LOAD;
                end else begin
                    finish = 1'b1;
                end
            end
            S_LOAD: begin
                cmd.load_top = 1'b1;
                state_next   = S_POP;
            end
            S_POP: begin
                if (!status.empty && status.lt) begin
                    cmd.pop    = 1'b1;
                    state_next = S_LOAD;
                end else begin
                    cmd.push_pop = 1'b1;
                    finish       = 1'b1;
                end
            end
            S_HOLD: begin
                if (can_emit) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (finish) begin
            if (!status.last) begin
                state_next = S_IDLE;
            end else if (can_emit) begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end else begin
                state_next = S_HOLD;
            end
        end
    end

    assign out_valid_next = cmd.emit || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/bpdn_datapath.sv =====
// ----------------------------------------------------------------------------
// bpdn_datapath
// key stack memory, cached top entry, deepest node tracking, result register
// ----------------------------------------------------------------------------
module bpdn_datapath #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bpdn_pkg::key_t       in_key,
    input  logic                 in_first,
    input  logic                 in_last,
    input  bpdn_pkg::cmd_t       cmd,
    output bpdn_pkg::status_t    status,
    output bpdn_pkg::key_t       out_key,
    output bpdn_pkg::level_t     out_level,
    output logic                 out_overflow
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    bpdn_pkg::entry_t stack_mem [STACK_DEPTH];
    bpdn_pkg::entry_t rd_data_reg;

    bpdn_pkg::key_t   key_reg;
    logic             first_reg;
    logic             last_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    bpdn_pkg::key_t   top_key_reg, top_key_next;
    bpdn_pkg::level_t top_level_reg, top_level_next;
    bpdn_pkg::level_t popped_reg;
    bpdn_pkg::key_t   best_key_reg, best_key_next;
    bpdn_pkg::level_t best_level_reg, best_level_next;
    logic             ovf_reg, ovf_next;
    bpdn_pkg::key_t   out_key_reg;
    bpdn_pkg::level_t out_level_reg;
    logic             out_ovf_reg;

    logic             full;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] rd_cnt;
    logic [IDX_W-1:0] rd_idx;
    bpdn_pkg::level_t new_level;
    logic             note_en;

    assign full         = (count_reg == CNT_W'(STACK_DEPTH));
    assign status.start = first_reg || (count_reg == '0);
    assign status.gt    = top_key_reg < key_reg;
    assign status.lt    = key_reg < top_key_reg;
    assign status.empty = (count_reg == '0);
    assign status.last  = last_reg;

    assign new_level = cmd.push_pop ? bpdn_pkg::level_inc(popped_reg)
                                    : bpdn_pkg::level_inc(top_level_reg);
    assign note_en   = cmd.push_gt || cmd.push_pop;

    assign rd_cnt = count_reg - CNT_W'(2);
    assign rd_idx = rd_cnt[IDX_W-1:0];
    assign wr_idx = cmd.start ? '0 : count_reg[IDX_W-1:0];
    assign wr_en  = cmd.start || cmd.push_pop || (cmd.push_gt && !full);

    always_comb begin
        count_next      = count_reg;
        top_key_next    = top_key_reg;
        top_level_next  = top_level_reg;
        best_key_next   = best_key_reg;
        best_level_next = best_level_reg;
        ovf_next        = ovf_reg;
        if (cmd.start) begin
            count_next      = CNT_W'(1);
            top_key_next    = key_reg;
            top_level_next  = '0;
            best_key_next   = key_reg;
            best_level_next = '0;
            ovf_next        = 1'b0;
        end else if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
        end else if (cmd.load_top) begin
            top_key_next   = rd_data_reg.key;
            top_level_next = rd_data_reg.level;
        end else if (wr_en) begin
            count_next     = count_reg + CNT_W'(1);
            top_key_next   = key_reg;
            top_level_next = new_level;
        end
        if (cmd.push_gt && full) begin
            ovf_next = 1'b1;
        end
        if (note_en) begin
            if (new_level > best_level_reg) begin
                best_level_next = new_level;
                best_key_next   = key_reg;
            end else if (new_level == best_level_reg && key_reg < best_key_reg) begin
                best_key_next = key_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_idx] <= '{key: key_reg, level: new_level & {10{!cmd.start}}};
        end
        rd_data_reg <= stack_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            best_key_reg   <= '0;
            best_level_reg <= '0;
            ovf_reg        <= 1'b0;
        end else begin
            count_reg      <= count_next;
            best_key_reg   <= best_key_next;
            best_level_reg <= best_level_next;
            ovf_reg        <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_key_reg   <= top_key_next;
        top_level_reg <= top_level_next;
        if (cmd.load) begin
            key_reg   <= in_key;
            first_reg <= in_first;
            last_reg  <= in_last;
        end
        if (cmd.pop) begin
            popped_reg <= top_level_reg;
        end
        if (cmd.emit) begin
            out_key_reg   <= best_key_next;
            out_level_reg <= best_level_next;
            out_ovf_reg   <= ovf_next;
        end
    end

    assign out_key      = out_key_reg;
    assign out_level    = out_level_reg;
    assign out_overflow = out_ovf_reg;

endmodule

// ===== design/bst_postorder_deepest_node_top.sv =====
// ----------------------------------------------------------------------------
// bst_postorder_deepest_node_top
// deepest node of a search tree given as reverse postorder keys
//
//   channel  dir  word contents
//   s_       in   tdata: key; tuser: first; tlast: last key of the sequence
//   m_       out  tdata: deepest_key, deepest_level, overflow
//
// an input word that starts a sequence, pushes or repeats the top key passes
// idle and eval, plus a load and a pop state per stack entry popped (one memory read each)
// the stack memory has one write port and one registered read port
// reset clears the stack count, the tracking state and the result valid
// a result waiting on m_ does not block input words; a last word stalls
// only while an earlier result is still not taken
// ----------------------------------------------------------------------------
module bst_postorder_deepest_node_top #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // key
    input  logic [0:0]                     s_tuser,   // first
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bpdn_pkg::M_TDATA_W-1:0] m_tdata    // deepest_key, deepest_level, overflow
);

    bpdn_pkg::cmd_t    cmd;
    bpdn_pkg::status_t status;
    bpdn_pkg::key_t    out_key;
    bpdn_pkg::level_t  out_level;
    logic              out_overflow;

    bpdn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bpdn_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_key       (s_tdata),
        .in_first     (s_tuser[0]),
        .in_last      (s_tlast),
        .cmd          (cmd),
        .status       (status),
        .out_key      (out_key),
        .out_level    (out_level),
        .out_overflow (out_overflow)
    );

    assign m_tdata = {5'b0, out_overflow, out_level, out_key};

endmodule
